// ===== src/i2c_sensor_master_top_defines.svh =====
// Assertion macros shared by the sensor master RTL.
// No dependencies; taken in by the top level with `include.
`ifndef I2C_SENSOR_MASTER_TOP_DEFINES_SVH
`define I2C_SENSOR_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ISM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ism assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ISM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ism assertion failed: next-cycle implication");

`endif

// ===== src/ism_pkg.sv =====
// Types and constants of the sensor master.
// No dependencies; used by the sequencer, the top level and the testbench.
package ism_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_AXES  = 2'd3
   } func_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NACK     = 2'd1;
   localparam logic [1:0] STATUS_BUS_BUSY = 2'd2;

   localparam logic CSR_DEVICE_WRITE_BYTE    = 1'b0;
   localparam logic CSR_BURST_START_REGISTER = 1'b1;

   localparam logic [7:0] DEVICE_WRITE_BYTE_RESET    = 8'h3c;
   localparam logic [7:0] BURST_START_REGISTER_RESET = 8'h03;
   localparam logic [7:0] READ_BIT                   = 8'h01;

   localparam int unsigned BURST_BYTES = 6;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic [7:0] device_write_byte;
      logic [7:0] burst_start_register;
   } cfg_type;

   typedef struct packed {
      logic              scl_out;
      logic              sda_out;
      logic              busy_res;
      logic              done_res;
      logic [1:0]        status;
      logic [7:0]        read_data;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } result_type;

endpackage

// ===== src/ism_req_if.sv =====
// Tick request channel: valid/ready plus command and sampled SDA.
// Depends on nothing.
interface ism_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] reg_addr;
   logic [7:0] wr_data;
   logic       sda_in;

   modport source (output valid, output func, output reg_addr, output wr_data,
                   output sda_in, input ready);
   modport sink   (input valid, input func, input reg_addr, input wr_data,
                   input sda_in, output ready);
endinterface

// ===== src/ism_rsp_if.sv =====
// Result channel: valid/ready plus bus drive, status and read data.
// Depends on nothing.
interface ism_rsp_if;
   logic               valid;
   logic               ready;
   logic               scl_out;
   logic               sda_out;
   logic               busy_res;
   logic               done_res;
   logic [1:0]         status;
   logic [7:0]         read_data;
   logic signed [15:0] axis_x;
   logic signed [15:0] axis_y;
   logic signed [15:0] axis_z;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output done_res, output status, output read_data, output axis_x,
                   output axis_y, output axis_z, input ready);
   modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                   input done_res, input status, input read_data, input axis_x,
                   input axis_y, input axis_z, output ready);
endinterface

// ===== src/ism_csr_if.sv =====
// Register write channel: valid/ready, register index and write data.
// Depends on nothing.
interface ism_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/ism_seq.sv =====
// Bus sequencer: one phase of the start/byte/ack/stop sequence per tick.
// Depends on ism_pkg.
module ism_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick,
   input  ism_pkg::req_type    req,
   input  ism_pkg::cfg_type    cfg,
   output ism_pkg::result_type result
);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_DEV, S_ACK1, S_REG, S_ACK2, S_DATA, S_ACK3,
      S_RSTART, S_DEVR, S_ACK4, S_RX, S_ACKOUT, S_STOP
   } step_type;

   typedef struct packed {
      logic [7:0] wr_data;
      logic [7:0] reg_addr;
      logic [1:0] func;
   } cmd_type;

   step_type   step_ff,  step_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] bitc_ff,  bitc_in;
   logic [2:0] bytec_ff, bytec_in;
   logic [7:0] shift_ff, shift_in;
   cmd_type    cmd_ff,   cmd_in;
   logic [1:0] stat_ff,  stat_in;
   logic [7:0] burst_ff [ism_pkg::BURST_BYTES];
   logic [7:0] burst_in [ism_pkg::BURST_BYTES];
   logic [7:0] lastrd_ff, lastrd_in;
   logic       sda_ff,   sda_in;
   logic       scl, busy, done;

   // Byte loaded into the shifter on entry to a step
   function automatic logic [7:0] load_shift(step_type step, logic [7:0] cur,
                                             cmd_type cmd, ism_pkg::cfg_type c);
      logic [7:0] v;
      v = cur;
      case (step)
         S_DEV:   v = c.device_write_byte;
         S_DEVR:  v = c.device_write_byte | ism_pkg::READ_BIT;
         S_REG:   v = (cmd.func == ism_pkg::FUNC_AXES) ? c.burst_start_register
                                                       : cmd.reg_addr;
         S_DATA:  v = cmd.wr_data;
         S_RX:    v = 8'h00;
         default: v = cur;
      endcase
      return v;
   endfunction

   always_comb begin
      logic       adv, more, is_out, is_rx, is_ackout, stop;
      logic [3:0] len;
      step_in   = step_ff;
      phase_in  = phase_ff;
      bitc_in   = bitc_ff;
      bytec_in  = bytec_ff;
      shift_in  = shift_ff;
      cmd_in    = cmd_ff;
      stat_in   = stat_ff;
      burst_in  = burst_ff;
      lastrd_in = lastrd_ff;
      sda_in    = sda_ff;
      scl       = 1'b1;
      busy      = 1'b0;
      done      = 1'b0;
      adv       = 1'b0;

      // Take a command only while idle; the command tick opens the start
      if (step_ff == S_IDLE && req.func != ism_pkg::FUNC_TICK) begin
         cmd_in   = '{wr_data: req.wr_data, reg_addr: req.reg_addr, func: req.func};
         stat_in  = ism_pkg::STATUS_OK;
         bytec_in = 3'd0;
         step_in  = S_START;
         phase_in = 2'd0;
         bitc_in  = 4'd0;
      end

      more      = (cmd_in.func == ism_pkg::FUNC_AXES) && (bytec_in < 3'd5);
      stop      = (step_in == S_STOP);
      is_out    = (step_in == S_DEV) || (step_in == S_REG) || (step_in == S_DATA) ||
                  (step_in == S_DEVR);
      is_rx     = (step_in == S_RX);
      is_ackout = (step_in == S_ACKOUT);
      len       = (is_out || is_rx) ? 4'd8 : 4'd1;

      if (step_in == S_IDLE) begin
         sda_in = 1'b1;
      end else if (step_in == S_START || step_in == S_RSTART || stop) begin
         busy = 1'b1;
         case (phase_in)
            2'd0: scl = 1'b0;
            2'd1: begin
               scl    = 1'b0;
               sda_in = !stop;
            end
            2'd2: begin
               scl = 1'b1;
               if (!stop) begin
                  sda_in = 1'b1;
                  if (!req.sda_in) stat_in = ism_pkg::STATUS_BUS_BUSY;
               end
            end
            default: begin
               scl    = 1'b1;
               sda_in = stop;
               done   = stop;
            end
         endcase
         if (phase_in == 2'd3) adv = 1'b1;
         else phase_in = phase_in + 2'd1;
      end else begin
         busy = 1'b1;
         if (phase_in == 2'd0) begin
            scl      = 1'b0;
            phase_in = 2'd1;
         end else if (phase_in == 2'd1) begin
            scl = 1'b0;
            if (is_out)         sda_in = shift_in[7];
            else if (is_ackout) sda_in = !more;
            else                sda_in = 1'b1;
            phase_in = 2'd2;
         end else begin
            scl = 1'b1;
            if (is_out) shift_in = {shift_in[6:0], 1'b0};
            else if (is_rx) shift_in = {shift_in[6:0], req.sda_in};
            else if (!is_ackout && req.sda_in && stat_in != ism_pkg::STATUS_BUS_BUSY)
               stat_in = ism_pkg::STATUS_NACK;
            bitc_in = bitc_in + 4'd1;
            if (bitc_in >= len) adv = 1'b1;
            else phase_in = 2'd0;
         end
      end

      if (adv) begin
         unique case (step_in)
            S_START:  step_in = S_DEV;
            S_DEV:    step_in = S_ACK1;
            S_ACK1:   step_in = S_REG;
            S_REG:    step_in = S_ACK2;
            S_ACK2:   step_in = (cmd_in.func == ism_pkg::FUNC_WRITE) ? S_DATA : S_RSTART;
            S_DATA:   step_in = S_ACK3;
            S_ACK3:   step_in = S_STOP;
            S_RSTART: step_in = S_DEVR;
            S_DEVR:   step_in = S_ACK4;
            S_ACK4:   step_in = S_RX;
            S_RX: begin
               if (cmd_in.func == ism_pkg::FUNC_AXES) begin
                  if (bytec_in < 3'(ism_pkg::BURST_BYTES)) burst_in[bytec_in] = shift_in;
               end else begin
                  lastrd_in = shift_in;
               end
               step_in = S_ACKOUT;
            end
            S_ACKOUT: begin
               if (more) begin
                  bytec_in = bytec_in + 3'd1;
                  step_in  = S_RX;
               end else begin
                  step_in = S_STOP;
               end
            end
            default:  step_in = S_IDLE;
         endcase
         phase_in = 2'd0;
         bitc_in  = 4'd0;
         shift_in = load_shift(step_in, shift_in, cmd_in, cfg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= S_IDLE;
         phase_ff  <= 2'd0;
         bitc_ff   <= 4'd0;
         bytec_ff  <= 3'd0;
         shift_ff  <= 8'h00;
         cmd_ff    <= '0;
         stat_ff   <= ism_pkg::STATUS_OK;
         burst_ff  <= '{default: 8'h00};
         lastrd_ff <= 8'h00;
         sda_ff    <= 1'b1;
      end else if (tick) begin
         step_ff   <= step_in;
         phase_ff  <= phase_in;
         bitc_ff   <= bitc_in;
         bytec_ff  <= bytec_in;
         shift_ff  <= shift_in;
         cmd_ff    <= cmd_in;
         stat_ff   <= stat_in;
         burst_ff  <= burst_in;
         lastrd_ff <= lastrd_in;
         sda_ff    <= sda_in;
      end
   end

   always_comb begin
      result.scl_out   = scl;
      result.sda_out   = sda_in;
      result.busy_res  = busy;
      result.done_res  = done;
      result.status    = stat_in;
      result.read_data = lastrd_in;
      result.axis_x    = {burst_in[0], burst_in[1]};
      result.axis_y    = {burst_in[2], burst_in[3]};
      result.axis_z    = {burst_in[4], burst_in[5]};
   end

endmodule

// ===== src/i2c_sensor_master_top.sv =====
// Sensor bus master, top level: register file, sequencer and result register.
// Depends on ism_pkg, the three channel interfaces, ism_seq and the defines header.
//
// Usage: each word on req_if is one bus tick. It carries the SDA level sampled
// on that tick and, while no sequence runs, a command in func (0 tick only,
// 1 register write, 2 register read, 3 three-axis burst read). Each tick gives
// exactly one word on rsp_if with the SCL/SDA drive for that tick, busy, a done
// pulse on the last tick of the stop, the status and the latest read data/axes.
// csr_if writes the device address byte (index 0) and the burst start register
// (index 1); it is always ready and should be used while no sequence runs.
// Throughput: one tick per cycle while the receiver takes each result word; the
// sequencer handles a whole tick combinationally and the result word sits in a single output register.
// A new tick is taken while the result register is empty or being drained, so
// a stalled receiver holds the result word and back-pressures req_if.
// Reset clears the sequencer to idle, both lines released, status ok, read
// data and axes zero, and loads the default register values.
`include "i2c_sensor_master_top_defines.svh"

module i2c_sensor_master_top (
   input logic        clock,
   input logic        reset,
   ism_req_if.sink    req_if,
   ism_rsp_if.source  rsp_if,
   ism_csr_if.sink    csr_if
);

   ism_pkg::cfg_type    cfg_ff;
   ism_pkg::req_type    req;
   ism_pkg::result_type result;
   ism_pkg::result_type rsp_data_ff;
   logic                rsp_valid_ff;
   logic                tick;
   logic                rsp_done;
   logic                rsp_idle;
   logic                rsp_released;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_write_byte    <= ism_pkg::DEVICE_WRITE_BYTE_RESET;
         cfg_ff.burst_start_register <= ism_pkg::BURST_START_REGISTER_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            ism_pkg::CSR_DEVICE_WRITE_BYTE:    cfg_ff.device_write_byte    <= csr_if.data;
            ism_pkg::CSR_BURST_START_REGISTER: cfg_ff.burst_start_register <= csr_if.data;
            default: ;
         endcase
      end
   end

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign tick         = req_if.valid && req_if.ready;
   assign req          = '{func: req_if.func, reg_addr: req_if.reg_addr,
                           wr_data: req_if.wr_data, sda_in: req_if.sda_in};

   ism_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .req    (req),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Hold the word until taken; refill on the same edge it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tick) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) rsp_data_ff <= result;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.scl_out   = rsp_data_ff.scl_out;
   assign rsp_if.sda_out   = rsp_data_ff.sda_out;
   assign rsp_if.busy_res  = rsp_data_ff.busy_res;
   assign rsp_if.done_res  = rsp_data_ff.done_res;
   assign rsp_if.status    = rsp_data_ff.status;
   assign rsp_if.read_data = rsp_data_ff.read_data;
   assign rsp_if.axis_x    = rsp_data_ff.axis_x;
   assign rsp_if.axis_y    = rsp_data_ff.axis_y;
   assign rsp_if.axis_z    = rsp_data_ff.axis_z;

   assign rsp_done     = rsp_valid_ff && rsp_data_ff.done_res;
   assign rsp_idle     = rsp_valid_ff && !rsp_data_ff.busy_res;
   assign rsp_released = rsp_data_ff.scl_out && rsp_data_ff.sda_out;

   `ISM_ASSERT_NEXT(a_tick_fills_result, clock, reset, tick, rsp_valid_ff)
   `ISM_ASSERT_IMPLY(a_done_releases_bus, clock, reset, rsp_done, rsp_released && rsp_data_ff.busy_res)
   `ISM_ASSERT_IMPLY(a_idle_releases_bus, clock, reset, rsp_idle, rsp_released && !rsp_data_ff.done_res)

endmodule

// ===== verif/i2c_sensor_master_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the sensor bus master: drives bus ticks, slave SDA and
// register writes, predicts every result word and compares it. Needs ism_pkg, the
// three channel interfaces and i2c_sensor_master_top.
module i2c_sensor_master_top_tb;

   localparam int RANDOM_ITEMS    = 240;
   localparam int RANDOM_PHASES   = 3;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int LONG_HOLD       = 300;

   localparam logic [2:0] CHK_STATUS = 3'b001;
   localparam logic [2:0] CHK_READ   = 3'b010;
   localparam logic [2:0] CHK_AXES   = 3'b100;

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_START, SEQ_DEV, SEQ_ACK1, SEQ_REG, SEQ_ACK2, SEQ_DATA, SEQ_ACK3,
      SEQ_RSTART, SEQ_DEVR, SEQ_ACK4, SEQ_RX, SEQ_ACKOUT, SEQ_STOP
   } seq_step_type;

   typedef struct {
      ism_pkg::func_type cmd;
      logic [7:0]  reg_addr;
      logic [7:0]  wr_data;
      logic [47:0] slave_bytes;   // byte 0 in the top bits
      int          nack_pct;
      int          busy_pct;
      bit          noise;
      logic [2:0]  checks;
      logic [1:0]  status;
      logic [7:0]  read_data;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } probe_row_type;

   logic clock;
   logic reset;

   ism_req_if req_if();
   ism_rsp_if rsp_if();
   ism_csr_if csr_if();

   i2c_sensor_master_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // master state as predicted
   seq_step_type      m_step;
   logic [1:0]        m_phase;
   logic [3:0]        m_bits;
   logic [2:0]        m_byte_idx;
   logic [7:0]        m_shift;
   ism_pkg::func_type m_func;
   logic [7:0]        m_reg;
   logic [7:0]        m_wdata;
   logic [1:0]        m_status;
   logic [7:0]        m_burst [ism_pkg::BURST_BYTES];
   logic [7:0]        m_rd;
   logic              m_sda;
   logic [7:0]        cfg_dev;
   logic [7:0]        cfg_burst;

   ism_pkg::result_type due_words [$];
   ism_pkg::result_type last_word;

   // slave behaviour for the sequence in flight
   logic [47:0] slv_bytes;
   int          nack_pct;
   int          busy_pct;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int items_sent;
   int fail_count;

   probe_row_type probe_rows [11] = '{
      '{ism_pkg::FUNC_TICK, 8'h00, 8'h00, 48'h0, 0, 0, 1'b0,
        CHK_STATUS | CHK_READ | CHK_AXES,
        ism_pkg::STATUS_OK, 8'h00, 16'h0000, 16'h0000, 16'h0000},
      '{ism_pkg::FUNC_WRITE, 8'h00, 8'h00, 48'h0, 0, 0, 1'b0, CHK_STATUS,
        ism_pkg::STATUS_OK, 8'h00, 16'h0, 16'h0, 16'h0},
      '{ism_pkg::FUNC_WRITE, 8'hff, 8'hff, 48'h0, 100, 0, 1'b0, CHK_STATUS,
        ism_pkg::STATUS_NACK, 8'h00, 16'h0, 16'h0, 16'h0},
      '{ism_pkg::FUNC_READ, 8'h00, 8'h00, 48'hff0000000000, 0, 0, 1'b0,
        CHK_STATUS | CHK_READ,
        ism_pkg::STATUS_OK, 8'hff, 16'h0, 16'h0, 16'h0},
      '{ism_pkg::FUNC_READ, 8'hff, 8'h00, 48'h000000000000, 0, 0, 1'b0,
        CHK_STATUS | CHK_READ,
        ism_pkg::STATUS_OK, 8'h00, 16'h0, 16'h0, 16'h0},
      '{ism_pkg::FUNC_READ, 8'h5a, 8'h00, 48'ha50000000000, 100, 100, 1'b0,
        CHK_STATUS | CHK_READ,
        ism_pkg::STATUS_BUS_BUSY, 8'ha5, 16'h0, 16'h0, 16'h0},
      '{ism_pkg::FUNC_AXES, 8'h00, 8'h00, 48'h80007fff0001, 0, 0, 1'b0,
        CHK_STATUS | CHK_AXES,
        ism_pkg::STATUS_OK, 8'h00, 16'h8000, 16'h7fff, 16'h0001},
      '{ism_pkg::FUNC_AXES, 8'h00, 8'h00, 48'hffff00008001, 100, 0, 1'b0,
        CHK_STATUS | CHK_AXES,
        ism_pkg::STATUS_NACK, 8'h00, 16'hffff, 16'h0000, 16'h8001},
      '{ism_pkg::FUNC_WRITE, 8'h81, 8'h7e, 48'h0, 0, 0, 1'b1, CHK_STATUS,
        ism_pkg::STATUS_OK, 8'h00, 16'h0, 16'h0, 16'h0},
      '{ism_pkg::FUNC_AXES, 8'h00, 8'h00, 48'h123456789abc, 0, 100, 1'b1,
        CHK_STATUS | CHK_AXES,
        ism_pkg::STATUS_BUS_BUSY, 8'h00, 16'h1234, 16'h5678, 16'h9abc},
      '{ism_pkg::FUNC_READ, 8'h3c, 8'h00, 48'h5a0000000000, 50, 50, 1'b0, 3'b000,
        ism_pkg::STATUS_OK, 8'h00, 16'h0, 16'h0, 16'h0}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function void load_step(input seq_step_type s);
      m_step  = s;
      m_phase = 2'd0;
      m_bits  = 4'd0;
      case (s)
         SEQ_DEV:  m_shift = cfg_dev;
         SEQ_DEVR: m_shift = cfg_dev | ism_pkg::READ_BIT;
         SEQ_REG:  m_shift = (m_func == ism_pkg::FUNC_AXES) ? cfg_burst : m_reg;
         SEQ_DATA: m_shift = m_wdata;
         SEQ_RX:   m_shift = 8'h00;
         default: ;
      endcase
   endfunction

   function bit burst_continues();
      return m_func == ism_pkg::FUNC_AXES && m_byte_idx < 3'd5;
   endfunction

   function void advance_step();
      case (m_step)
         SEQ_START:  load_step(SEQ_DEV);
         SEQ_DEV:    load_step(SEQ_ACK1);
         SEQ_ACK1:   load_step(SEQ_REG);
         SEQ_REG:    load_step(SEQ_ACK2);
         SEQ_ACK2:   load_step(m_func == ism_pkg::FUNC_WRITE ? SEQ_DATA : SEQ_RSTART);
         SEQ_DATA:   load_step(SEQ_ACK3);
         SEQ_ACK3:   load_step(SEQ_STOP);
         SEQ_RSTART: load_step(SEQ_DEVR);
         SEQ_DEVR:   load_step(SEQ_ACK4);
         SEQ_ACK4:   load_step(SEQ_RX);
         SEQ_RX: begin
            if (m_func == ism_pkg::FUNC_AXES) m_burst[m_byte_idx] = m_shift;
            else m_rd = m_shift;
            load_step(SEQ_ACKOUT);
         end
         SEQ_ACKOUT: begin
            if (burst_continues()) begin
               m_byte_idx++;
               load_step(SEQ_RX);
            end else begin
               load_step(SEQ_STOP);
            end
         end
         default: load_step(SEQ_IDLE);
      endcase
   endfunction

   function void reset_master();
      cfg_dev    = ism_pkg::DEVICE_WRITE_BYTE_RESET;
      cfg_burst  = ism_pkg::BURST_START_REGISTER_RESET;
      m_step     = SEQ_IDLE;
      m_phase    = 2'd0;
      m_bits     = 4'd0;
      m_byte_idx = 3'd0;
      m_shift    = 8'h00;
      m_func     = ism_pkg::FUNC_TICK;
      m_reg      = 8'h00;
      m_wdata    = 8'h00;
      m_status   = ism_pkg::STATUS_OK;
      m_rd       = 8'h00;
      m_sda      = 1'b1;
      foreach (m_burst[i]) m_burst[i] = 8'h00;
   endfunction

   // one bus tick: update the master and queue the word it must produce
   function void step_master(input ism_pkg::req_type r);
      ism_pkg::result_type w;
      bit         stop;
      bit         is_out;
      bit         is_rx;
      bit         is_ack_out;
      int         len;
      w = '0;
      w.scl_out = 1'b1;
      if (m_step == SEQ_IDLE && r.func != ism_pkg::FUNC_TICK) begin
         m_func     = ism_pkg::func_type'(r.func);
         m_reg      = r.reg_addr;
         m_wdata    = r.wr_data;
         m_status   = ism_pkg::STATUS_OK;
         m_byte_idx = 3'd0;
         load_step(SEQ_START);
      end
      if (m_step == SEQ_IDLE) begin
         m_sda = 1'b1;
      end else if (m_step == SEQ_START || m_step == SEQ_RSTART || m_step == SEQ_STOP) begin
         stop = (m_step == SEQ_STOP);
         w.busy_res = 1'b1;
         case (m_phase)
            2'd0: w.scl_out = 1'b0;
            2'd1: begin
               w.scl_out = 1'b0;
               m_sda = !stop;
            end
            2'd2: begin
               if (!stop) begin
                  m_sda = 1'b1;
                  if (!r.sda_in) m_status = ism_pkg::STATUS_BUS_BUSY;
               end
            end
            default: begin
               m_sda = stop;
               w.done_res = stop;
            end
         endcase
         if (m_phase == 2'd3) advance_step();
         else m_phase++;
      end else begin
         is_out = (m_step == SEQ_DEV || m_step == SEQ_REG || m_step == SEQ_DATA ||
                   m_step == SEQ_DEVR);
         is_rx      = (m_step == SEQ_RX);
         is_ack_out = (m_step == SEQ_ACKOUT);
         len = (is_out || is_rx) ? 8 : 1;
         w.busy_res = 1'b1;
         if (m_phase == 2'd0) begin
            w.scl_out = 1'b0;
            m_phase = 2'd1;
         end else if (m_phase == 2'd1) begin
            w.scl_out = 1'b0;
            if (is_out) m_sda = m_shift[7];
            else if (is_ack_out) m_sda = !burst_continues();
            else m_sda = 1'b1;
            m_phase = 2'd2;
         end else begin
            if (is_out) m_shift = m_shift << 1;
            else if (is_rx) m_shift = {m_shift[6:0], r.sda_in};
            else if (!is_ack_out && r.sda_in && m_status != ism_pkg::STATUS_BUS_BUSY)
               m_status = ism_pkg::STATUS_NACK;
            m_bits++;
            if (int'(m_bits) >= len) advance_step();
            else m_phase = 2'd0;
         end
      end
      w.sda_out   = m_sda;
      w.status    = m_status;
      w.read_data = m_rd;
      w.axis_x    = {m_burst[0], m_burst[1]};
      w.axis_y    = {m_burst[2], m_burst[3]};
      w.axis_z    = {m_burst[4], m_burst[5]};
      due_words.push_back(w);
   endfunction

   // SDA level the slave puts on the line for the coming tick
   function bit slave_sda();
      int k;
      if (m_phase != 2'd2) return 1'($urandom_range(0, 1));
      case (m_step)
         SEQ_START, SEQ_RSTART: return ($urandom_range(0, 99) < busy_pct) ? 1'b0 : 1'b1;
         SEQ_ACK1, SEQ_ACK2, SEQ_ACK3, SEQ_ACK4:
            return ($urandom_range(0, 99) < nack_pct) ? 1'b1 : 1'b0;
         SEQ_RX: begin
            k = 47 - 8 * int'(m_byte_idx) - int'(m_bits);
            return slv_bytes[k];
         end
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
         fail_count++;
      end
   endtask

   task automatic send_tick(input ism_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.func     <= r.func;
      req_if.reg_addr <= r.reg_addr;
      req_if.wr_data  <= r.wr_data;
      req_if.sda_in   <= r.sda_in;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      step_master(r);
      items_sent++;
   endtask

   // issue a command word, then tick until the sequence is back to idle
   task automatic run_command(input ism_pkg::func_type f, input logic [7:0] ra,
                              input logic [7:0] wd, input bit noise);
      ism_pkg::req_type r;
      r.func     = f;
      r.reg_addr = ra;
      r.wr_data  = wd;
      r.sda_in   = slave_sda();
      send_tick(r);
      while (m_step != SEQ_IDLE) begin
         r.func     = noise ? 2'($urandom_range(0, 3)) : ism_pkg::FUNC_TICK;
         r.reg_addr = 8'($urandom_range(0, 255));
         r.wr_data  = 8'($urandom_range(0, 255));
         r.sda_in   = slave_sda();
         send_tick(r);
      end
   endtask

   task automatic drain_words();
      req_if.valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      if (idx == ism_pkg::CSR_DEVICE_WRITE_BYTE) cfg_dev = value;
      else cfg_burst = value;
   endtask

   task automatic set_config(input logic [7:0] dev, input logic [7:0] burst);
      drain_words();
      repeat (2) @(posedge clock);
      csr_write(ism_pkg::CSR_DEVICE_WRITE_BYTE, dev);
      csr_write(ism_pkg::CSR_BURST_START_REGISTER, burst);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 13; recv_idle_pct = 83; end
         1: begin send_idle_pct = 83; recv_idle_pct = 13; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
   endtask

   // receiver: random stalls, plus a long hold when asked
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : word_check
      ism_pkg::result_type want;
      ism_pkg::result_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.scl_out   = rsp_if.scl_out;
         got.sda_out   = rsp_if.sda_out;
         got.busy_res  = rsp_if.busy_res;
         got.done_res  = rsp_if.done_res;
         got.status    = rsp_if.status;
         got.read_data = rsp_if.read_data;
         got.axis_x    = rsp_if.axis_x;
         got.axis_y    = rsp_if.axis_y;
         got.axis_z    = rsp_if.axis_z;
         last_word = got;
         if (due_words.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = due_words.pop_front();
            compare_field("scl_out", want.scl_out, got.scl_out);
            compare_field("sda_out", want.sda_out, got.sda_out);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("status", want.status, got.status);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("axis_x", want.axis_x, got.axis_x);
            compare_field("axis_y", want.axis_y, got.axis_y);
            compare_field("axis_z", want.axis_z, got.axis_z);
         end
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
             (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("[i2c_sensor_master_top] ERROR");
      $finish;
   end

   initial begin : stimulus
      int                phase_end;
      bit                clean;
      ism_pkg::func_type f;
      fail_count  = 0;
      items_sent  = 0;
      hold_cycles = 0;
      nack_pct    = 0;
      busy_pct    = 0;
      slv_bytes   = '0;
      last_word   = '0;
      set_idling(0);
      reset_master();
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.func     <= ism_pkg::FUNC_TICK;
      req_if.reg_addr <= 8'h00;
      req_if.wr_data  <= 8'h00;
      req_if.sda_in   <= 1'b1;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= ism_pkg::CSR_DEVICE_WRITE_BYTE;
      csr_if.data     <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed sequences at the reset register values
      foreach (probe_rows[i]) begin
         slv_bytes = probe_rows[i].slave_bytes;
         nack_pct  = probe_rows[i].nack_pct;
         busy_pct  = probe_rows[i].busy_pct;
         run_command(probe_rows[i].cmd, probe_rows[i].reg_addr, probe_rows[i].wr_data,
                     probe_rows[i].noise);
         drain_words();
         if (probe_rows[i].checks & CHK_STATUS)
            compare_field("final status", probe_rows[i].status, last_word.status);
         if (probe_rows[i].checks & CHK_READ)
            compare_field("final read_data", probe_rows[i].read_data, last_word.read_data);
         if (probe_rows[i].checks & CHK_AXES) begin
            compare_field("final axis_x", probe_rows[i].x, last_word.axis_x);
            compare_field("final axis_y", probe_rows[i].y, last_word.axis_y);
            compare_field("final axis_z", probe_rows[i].z, last_word.axis_z);
         end
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_idling(ph);
         case (ph)
            0: set_config(8'h00, 8'h00);
            1: set_config(8'hfe, 8'hff);
            default: set_config(8'($urandom_range(0, 254)), 8'($urandom_range(0, 255)));
         endcase
         // hold the receiver while the sender keeps offering, so the block stalls
         if (ph == 0) hold_cycles = LONG_HOLD;
         phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < phase_end) begin
            repeat ($urandom_range(0, 3))
               run_command(ism_pkg::FUNC_TICK, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'b0);
            clean     = ($urandom_range(0, 99) < 80);
            slv_bytes = {$urandom, 16'($urandom)};
            nack_pct  = clean ? 0 : $urandom_range(0, 100);
            busy_pct  = clean ? 0 : $urandom_range(0, 60);
            f = ism_pkg::func_type'($urandom_range(1, 3));
            run_command(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        clean ? 1'b0 : 1'($urandom_range(0, 1)));
         end
         drain_words();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("[i2c_sensor_master_top] OK");
      else
         $display("[i2c_sensor_master_top] ERROR");
      $finish;
   end

endmodule
